/* sv/multiset_store_defines.svh */
// Assertion macros shared by the multiset store checker.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTISET_STORE_DEFINES_SVH
`define MULTISET_STORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define MS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multiset_store: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define MS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("multiset_store: next-cycle check failed");

`endif

/* sv/ms_pkg.sv */
// Types shared by the multiset store controller, datapath and top level.
// Depends on nothing.
package ms_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_COUNT  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the incoming word and start a new scan
        logic issue;      // read the entry at the scan pointer
        logic read_last;  // read the last occupied entry
        logic move;       // write the last entry into the matched slot
        logic add_write;  // append the key
        logic clear;      // empty the store
        logic finish;     // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action act;
        logic    occ_zero;
        logic    scan_last;
        logic    full;
        logic    found;
        logic    out_free;
    } t_sts;

endpackage

/* sv/ms_ctrl.sv */
// Sequencing state machine of the multiset store.
// Depends on ms_pkg for the command and status types.
module ms_ctrl
    import ms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_FLUSH = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.occ_zero ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // The last read is compared during this cycle.
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_DONE;
                case (i_sts.act)
                    ACT_ADD: begin
                        o_cmd.add_write = !i_sts.full;
                    end
                    ACT_REMOVE: begin
                        if (i_sts.found) begin
                            n_state = S_FETCH;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                o_cmd.read_last = 1'b1;
                n_state         = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/ms_datapath.sv */
// Entry memory, scan counters, match logic and result register of the multiset store.
// Depends on ms_pkg for the command and status types.
module ms_datapath
    import ms_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_value,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_stall,
    output logic        o_valid,
    output logic        o_ok,
    output logic [4:0]  o_frequency,
    output logic [4:0]  o_size
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_WIDTH-1:0] r_mem [CAPACITY];

    t_action                r_act;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CW-1:0]          r_occ;
    logic [CW-1:0]          r_ptr;
    logic [CW-1:0]          r_freq;
    logic                   r_found;
    logic                   r_ok;
    logic [AW-1:0]          r_hit_idx;
    logic [AW-1:0]          r_rd_idx;
    logic                   r_rd_vld;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_out_vld;
    logic                   r_out_ok;
    logic [4:0]             r_out_freq;
    logic [4:0]             r_out_size;

    logic [VALUE_WIDTH+31:0] key_ext;
    logic [CW-1:0]           occ_m1;
    logic [AW-1:0]           rd_addr;
    logic                    hit;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [VALUE_WIDTH-1:0]  wr_data;
    logic [CW+4:0]           freq_ext;
    logic [CW+4:0]           occ_ext;

    // Bits of the word above the entry width are dropped; narrower words are zero-filled.
    assign key_ext  = {{VALUE_WIDTH{1'b0}}, i_value};
    assign occ_m1   = r_occ - CW'(1);
    assign rd_addr  = i_cmd.read_last ? occ_m1[AW-1:0] : r_ptr[AW-1:0];
    assign hit      = r_rd_vld && (r_rd_data == r_key);
    assign wr_en    = i_cmd.add_write || i_cmd.move;
    assign wr_addr  = i_cmd.move ? r_hit_idx : r_occ[AW-1:0];
    assign wr_data  = i_cmd.move ? r_rd_data : r_key;
    assign freq_ext = {5'b0, r_freq};
    assign occ_ext  = {5'b0, r_occ};

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue || i_cmd.read_last) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.add_write) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_cmd.move) begin
                r_occ <= occ_m1;
            end else if (i_cmd.clear) begin
                r_occ <= '0;
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= t_action'(i_action);
            r_key   <= key_ext[VALUE_WIDTH-1:0];
            r_ptr   <= '0;
            r_freq  <= '0;
            r_found <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (hit) begin
                r_freq <= r_freq + CW'(1);
                if (!r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
            end
            if (i_cmd.add_write || i_cmd.move || i_cmd.clear) begin
                r_ok <= 1'b1;
            end
        end
        if (i_cmd.issue) begin
            r_rd_idx <= r_ptr[AW-1:0];
        end
        if (i_cmd.finish) begin
            r_out_ok   <= r_ok;
            r_out_freq <= freq_ext[4:0];
            r_out_size <= occ_ext[4:0];
        end
    end

    assign o_sts.act       = r_act;
    assign o_sts.occ_zero  = (r_occ == '0);
    assign o_sts.scan_last = (r_ptr == occ_m1);
    assign o_sts.full      = (r_occ == CW'(CAPACITY));
    assign o_sts.found     = r_found;
    assign o_sts.out_free  = !r_out_vld || !i_stall;

    assign o_valid     = r_out_vld;
    assign o_ok        = r_out_ok;
    assign o_frequency = r_out_freq;
    assign o_size      = r_out_size;

endmodule

/* sv/multiset_store.sv */
// Multiset store: every held entry is read once through the single memory port, so the time
// from acceptance to result grows with the entries held; a remove that finds a match adds a
// fetch and a move, and an empty store skips the scan. The next word is taken only after
// the result is loaded, so the block works on one word at a time.
// Synchronous active-low reset empties the store and drops any pending result; the entry
// memory itself is not cleared, as only slots below the occupancy are ever read.
module multiset_store
    import ms_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [4:0]  o_frequency,
    output logic [4:0]  o_size
);

    // The controller steps through scan, apply and, for a remove that hits, a fetch of the
    // last entry and its move into the freed slot. The datapath owns all storage and the
    // result register, so a finished result can wait there while the next word is taken.
    t_cmd cmd;
    t_sts sts;

    ms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The scan issues one read a cycle; the registered read data is compared with the
    // key in the next cycle, counting matches and noting the first matching slot.
    ms_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_ok        (o_ok),
        .o_frequency (o_frequency),
        .o_size      (o_size)
    );

endmodule

/* sv/ms_checker.sv */
// Port-level checks of the multiset store, bound to the top level.
// Depends on multiset_store_defines.svh for the assertion macros.
`include "multiset_store_defines.svh"

module ms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_ok,
    input logic [4:0] o_frequency,
    input logic [4:0] o_size
);

    // A result held back by the consumer keeps its contents.
    `MS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_ok) && $stable(o_frequency) && $stable(o_size))

    // Accepting a word makes the block busy on the next cycle.
    `MS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // A new result only appears at the end of a busy period.
    `MS_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // A result never appears in the cycle right after a word was taken.
    `MS_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_valid && !o_stall && !o_valid, !o_valid)

endmodule

bind multiset_store ms_checker u_ms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_ok        (o_ok),
    .o_frequency (o_frequency),
    .o_size      (o_size)
);

/* sim/multiset_store_test.sv */
// Self-checking testbench for the multiset store: drives action and value words, predicts
// each result and compares it with what the block returns.
// Depends on ms_pkg and multiset_store.
`timescale 1ns / 100ps

module multiset_store_test;
    import ms_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int SEND_WORDS   = 1825;  // random words, spread over three idling phases
    localparam int SETTLE_WAIT  = 40;    // longest run is a hitting remove on a full store
    localparam int RUN_LIMIT_NS = 5_000_000;

    // One expected result, as the block presents it.
    typedef struct packed {
        logic       ok;
        logic [4:0] frequency;
        logic [4:0] size;
    } t_store_result;

    // Holds its own copy of the bag and the queue of results still owed by the block.
    class multiset_scoreboard;
        logic [31:0]   held [STORE_DEPTH];
        int unsigned   held_count;
        t_store_result owed [$];
        int unsigned   errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        // Apply one accepted word to the bag and queue the result it must produce.
        function void note_word(t_action act, logic [31:0] val);
            t_store_result res;
            int unsigned   hit_count;
            bit            found;
            hit_count = 0;
            found     = 1'b0;
            for (int i = 0; i < held_count; i++) begin
                if (held[i] == val) begin
                    hit_count++;
                end
            end
            res.ok = 1'b0;
            case (act)
                ACT_ADD: begin
                    if (held_count < STORE_DEPTH) begin
                        held[held_count] = val;
                        held_count++;
                        res.ok = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    // The first match takes the last entry in its place.
                    for (int i = 0; i < held_count; i++) begin
                        if (!found && held[i] == val) begin
                            held[i] = held[held_count - 1];
                            found   = 1'b1;
                        end
                    end
                    if (found) begin
                        held_count--;
                        res.ok = 1'b1;
                    end
                end
                ACT_COUNT: begin
                end
                ACT_CLEAR: begin
                    held_count = 0;
                    res.ok     = 1'b1;
                end
            endcase
            res.frequency = hit_count[4:0];
            res.size      = held_count[4:0];
            owed.insert(owed.size(), res);
        endfunction

        function void check_result(logic ok, logic [4:0] frequency, logic [4:0] size);
            t_store_result want;
            if (owed.size() == 0) begin
                $error("result with nothing owed: ok %0d frequency %0d size %0d",
                       ok, frequency, size);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (ok !== want.ok) begin
                $error("ok: expected %0d, got %0d", want.ok, ok);
                errors++;
            end
            if (frequency !== want.frequency) begin
                $error("frequency: expected %0d, got %0d", want.frequency, frequency);
                errors++;
            end
            if (size !== want.size) begin
                $error("size: expected %0d, got %0d", want.size, size);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic        o_ok;
    logic [4:0]  o_frequency;
    logic [4:0]  o_size;

    multiset_scoreboard board;

    // Per-cycle chances, in percent, that the sender holds back and the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned take_stall_pct;

    // Small pool of values so that removes and counts find matches often.
    logic [31:0] value_pool [4];
    int unsigned pool_used;

    multiset_store #(
        .CAPACITY    (STORE_DEPTH),
        .VALUE_WIDTH (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ok        (o_ok),
        .o_frequency (o_frequency),
        .o_size      (o_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver decides its stall at each falling edge, so it is steady at the rising one.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < take_stall_pct);
    end

    // A result word is taken when it is valid and not stalled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_ok, o_frequency, o_size);
        end
    end

    // Present one word and hold it until the block takes it. Idle cycles come first, each
    // one starting at a falling edge, so valid is written only once per time step.
    task automatic put_word(t_action act, logic [31:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        board.note_word(act, val);
    endtask

    task automatic refresh_pool();
        // Now and then the pool shrinks to one value, so the whole store can fill with it
        // and the frequency reaches its top.
        pool_used = $urandom_range(4, 1);
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(9))
                0:       value_pool[i] = 32'h0000_0000;
                1:       value_pool[i] = 32'hFFFF_FFFF;
                default: value_pool[i] = $urandom();
            endcase
        end
    endtask

    // Random words, mostly adds and removes on pooled values; clears keep the store from
    // sticking at full, and a share of fully random values exercises every value bit.
    task automatic random_words(int unsigned n);
        int unsigned pick;
        logic [31:0] val;
        t_action     act;
        for (int unsigned k = 0; k < n; k++) begin
            if (k % 48 == 0) begin
                refresh_pool();
            end
            if ($urandom_range(99) < 85) begin
                val = value_pool[$urandom_range(pool_used - 1)];
            end else begin
                val = $urandom();
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                act = ACT_ADD;
            end else if (pick < 70) begin
                act = ACT_REMOVE;
            end else if (pick < 93) begin
                act = ACT_COUNT;
            end else begin
                act = ACT_CLEAR;
            end
            put_word(act, val);
        end
    endtask

    initial begin
        board          = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_ADD;
        i_value        = 32'h0;
        i_stall        = 1'b0;
        send_idle_pct  = 36;
        take_stall_pct = 48;
        pool_used      = 1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: clear on an empty store, the extreme values, a remove that
        // misses, a remove that moves the last entry into the first slot, filling the
        // store, an add that is refused when full, a count at fifteen and a final clear.
        put_word(ACT_CLEAR, 32'hFFFF_FFFF);
        put_word(ACT_ADD, 32'h0000_0000);
        put_word(ACT_ADD, 32'hFFFF_FFFF);
        put_word(ACT_COUNT, 32'h0000_0000);
        put_word(ACT_COUNT, 32'hFFFF_FFFF);
        put_word(ACT_REMOVE, 32'h1234_5678);
        put_word(ACT_REMOVE, 32'h0000_0000);
        for (int i = 0; i < 15; i++) begin
            put_word(ACT_ADD, 32'hA5A5_A5A5);
        end
        put_word(ACT_ADD, 32'h5A5A_5A5A);
        put_word(ACT_COUNT, 32'hA5A5_A5A5);
        put_word(ACT_CLEAR, 32'h5A5A_5A5A);

        random_words(610);

        // Second phase: the idling of the two sides swapped over.
        send_idle_pct  = 48;
        take_stall_pct = 36;
        random_words(610);

        // Third phase: back to back in both directions.
        send_idle_pct  = 0;
        take_stall_pct = 0;
        random_words(SEND_WORDS - 1220);

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (board.owed.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

/* multiset_store.f */
+incdir+sv
sv/ms_pkg.sv
sv/ms_ctrl.sv
sv/ms_datapath.sv
sv/multiset_store.sv
sv/ms_checker.sv
sim/multiset_store_test.sv
